// ===== hw/rtl/gamepad_input_conditioner_defines.svh =====
// Assertion macros used by the gamepad input conditioner top level
`ifndef GAMEPAD_INPUT_CONDITIONER_DEFINES_SVH
`define GAMEPAD_INPUT_CONDITIONER_DEFINES_SVH

// Same-cycle implication, clocked on clk, off during reset
`define GIC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset
`define GIC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/gic_pkg.sv =====
// Shared types, codes and constants of the gamepad input conditioner
package gic_pkg;

    // Pad count and the width of a pad select
    localparam int NUM_PADS = 4;
    localparam int PAD_W    = (NUM_PADS > 1) ? $clog2(NUM_PADS) : 1;

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] REG_DZ_MODE   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_LEFT_DZ   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_RIGHT_DZ  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TRIG_THR  = 2'd3;

    // Dead zone modes
    localparam logic [1:0] DZ_OFF    = 2'd0;
    localparam logic [1:0] DZ_AXIS   = 2'd1;
    localparam logic [1:0] DZ_CENTER = 2'd2;

    // Result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_BAD_INDEX = 2'd1;
    localparam logic [1:0] ST_NO_DRIVER = 2'd2;

    // Register reset values
    localparam logic [1:0]  DZ_MODE_RST   = DZ_OFF;
    localparam logic [15:0] LEFT_DZ_RST   = 16'd7849;
    localparam logic [15:0] RIGHT_DZ_RST  = 16'd8689;
    localparam logic [7:0]  TRIG_THR_RST  = 8'd30;

    // Configuration register set
    typedef struct packed {
        logic [1:0]  dz_mode;
        logic [15:0] left_dz;
        logic [15:0] right_dz;
        logic [7:0]  trig_thr;
    } cfg_t;

    // One input item as held in the input register
    typedef struct packed {
        logic [2:0]         pad_index;
        logic               driver_present;
        logic               device_connected;
        logic [15:0]        raw_buttons;
        logic [7:0]         raw_left_trigger;
        logic [7:0]         raw_right_trigger;
        logic signed [15:0] raw_left_x;
        logic signed [15:0] raw_left_y;
        logic signed [15:0] raw_right_x;
        logic signed [15:0] raw_right_y;
    } in_item_t;

    // Four thumbstick axes
    typedef struct packed {
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
    } axes_t;

    // Per-pad tracking results handed to the top level
    typedef struct packed {
        logic [1:0]  status;
        logic        is_connected;
        logic        was_inserted;
        logic        was_removed;
        logic        data_en;
        logic [15:0] pressed;
        logic        left_edge;
        logic        right_edge;
    } trk_res_t;

    // One result item as held in the output register
    typedef struct packed {
        logic [1:0]         status;
        logic               is_connected;
        logic               was_inserted;
        logic               was_removed;
        logic signed [15:0] left_x;
        logic signed [15:0] left_y;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic [15:0]        held_buttons;
        logic [15:0]        pressed_buttons;
        logic               left_trigger_edge;
        logic               right_trigger_edge;
    } out_item_t;

endpackage

// ===== hw/rtl/gic_channels.sv =====
// Channel interfaces: raw sample in, conditioned result out, register writes

// Raw gamepad sample channel
interface gic_sample_if;
    logic               valid;
    logic               ready;
    logic [2:0]         pad_index;
    logic               driver_present;
    logic               device_connected;
    logic [15:0]        raw_buttons;
    logic [7:0]         raw_left_trigger;
    logic [7:0]         raw_right_trigger;
    logic signed [15:0] raw_left_x;
    logic signed [15:0] raw_left_y;
    logic signed [15:0] raw_right_x;
    logic signed [15:0] raw_right_y;

    modport source (
        output valid, pad_index, driver_present, device_connected, raw_buttons,
               raw_left_trigger, raw_right_trigger, raw_left_x, raw_left_y,
               raw_right_x, raw_right_y,
        input  ready
    );
    modport sink (
        input  valid, pad_index, driver_present, device_connected, raw_buttons,
               raw_left_trigger, raw_right_trigger, raw_left_x, raw_left_y,
               raw_right_x, raw_right_y,
        output ready
    );
endinterface

// Conditioned result channel
interface gic_result_if;
    logic               valid;
    logic               ready;
    logic [1:0]         status;
    logic               is_connected;
    logic               was_inserted;
    logic               was_removed;
    logic signed [15:0] left_x;
    logic signed [15:0] left_y;
    logic signed [15:0] right_x;
    logic signed [15:0] right_y;
    logic [15:0]        held_buttons;
    logic [15:0]        pressed_buttons;
    logic               left_trigger_edge;
    logic               right_trigger_edge;

    modport source (
        output valid, status, is_connected, was_inserted, was_removed, left_x,
               left_y, right_x, right_y, held_buttons, pressed_buttons,
               left_trigger_edge, right_trigger_edge,
        input  ready
    );
    modport sink (
        input  valid, status, is_connected, was_inserted, was_removed, left_x,
               left_y, right_x, right_y, held_buttons, pressed_buttons,
               left_trigger_edge, right_trigger_edge,
        output ready
    );
endinterface

// Register write channel
interface gic_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [gic_pkg::CFG_IDX_W-1:0]  reg_index;
    logic [gic_pkg::CFG_DATA_W-1:0] reg_data;

    modport source (output valid, reg_index, reg_data, input ready);
    modport sink   (input valid, reg_index, reg_data, output ready);
endinterface

// ===== hw/rtl/gic_cfg_regs.sv =====
// Configuration registers: dead zone mode, dead zones, trigger threshold
module gic_cfg_regs (
    input  logic          clk,
    input  logic          rst_n,
    gic_cfg_if.sink       cfg,
    output gic_pkg::cfg_t cfg_q
);
    import gic_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Writes are always taken
    assign cfg.ready = 1'b1;

    // Decode a register write
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg.valid)
        begin
            case (cfg.reg_index)
                REG_DZ_MODE:  cfg_next.dz_mode  = cfg.reg_data[1:0];
                REG_LEFT_DZ:  cfg_next.left_dz  = cfg.reg_data[15:0];
                REG_RIGHT_DZ: cfg_next.right_dz = cfg.reg_data[15:0];
                REG_TRIG_THR: cfg_next.trig_thr = cfg.reg_data[7:0];
                default:      cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.dz_mode  <= DZ_MODE_RST;
            cfg_reg.left_dz  <= LEFT_DZ_RST;
            cfg_reg.right_dz <= RIGHT_DZ_RST;
            cfg_reg.trig_thr <= TRIG_THR_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg_q = cfg_reg;
endmodule

// ===== hw/rtl/gic_dead_zone.sv =====
// Thumbstick dead zone: off, per axis, or center region per stick
module gic_dead_zone (
    input  gic_pkg::cfg_t  cfg_q,
    input  gic_pkg::axes_t raw,
    output gic_pkg::axes_t cooked
);
    import gic_pkg::*;

    // Magnitude with -32768 giving 32768
    function automatic logic [16:0] mag(input logic signed [15:0] v);
        logic [16:0] ext;
        ext = {v[15], v};
        return v[15] ? 17'(-ext) : ext;
    endfunction

    logic lx_small;
    logic ly_small;
    logic rx_small;
    logic ry_small;
    logic lx_zero;
    logic ly_zero;
    logic rx_zero;
    logic ry_zero;

    assign lx_small = mag(raw.left_x)  < {1'b0, cfg_q.left_dz};
    assign ly_small = mag(raw.left_y)  < {1'b0, cfg_q.left_dz};
    assign rx_small = mag(raw.right_x) < {1'b0, cfg_q.right_dz};
    assign ry_small = mag(raw.right_y) < {1'b0, cfg_q.right_dz};

    // Zeroing decision by mode; the unused code behaves as off
    always_comb
    begin
        case (cfg_q.dz_mode)
            DZ_AXIS:
            begin
                lx_zero = lx_small;
                ly_zero = ly_small;
                rx_zero = rx_small;
                ry_zero = ry_small;
            end
            DZ_CENTER:
            begin
                lx_zero = lx_small && ly_small;
                ly_zero = lx_small && ly_small;
                rx_zero = rx_small && ry_small;
                ry_zero = rx_small && ry_small;
            end
            default:
            begin
                lx_zero = 1'b0;
                ly_zero = 1'b0;
                rx_zero = 1'b0;
                ry_zero = 1'b0;
            end
        endcase
    end

    assign cooked.left_x  = lx_zero ? 16'sd0 : raw.left_x;
    assign cooked.left_y  = ly_zero ? 16'sd0 : raw.left_y;
    assign cooked.right_x = rx_zero ? 16'sd0 : raw.right_x;
    assign cooked.right_y = ry_zero ? 16'sd0 : raw.right_y;
endmodule

// ===== hw/rtl/gic_pad_tracker.sv =====
// Per-pad connection, button and trigger history with edge detection
module gic_pad_tracker (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              commit,
    input  gic_pkg::in_item_t item,
    input  logic [7:0]        trig_thr,
    output gic_pkg::trk_res_t res
);
    import gic_pkg::*;

    logic [NUM_PADS-1:0] online_reg;
    logic [15:0]         prev_btn_reg [NUM_PADS];
    logic [7:0]          prev_lt_reg  [NUM_PADS];
    logic [7:0]          prev_rt_reg  [NUM_PADS];

    logic             idx_ok;
    logic [PAD_W-1:0] pad;
    logic             was_on;
    logic             inserted;
    logic [15:0]      prev_btn;
    logic [7:0]       prev_lt;
    logic [7:0]       prev_rt;
    logic             lt_on;
    logic             rt_on;
    logic             prev_lt_on;
    logic             prev_rt_on;

    assign idx_ok = {1'b0, item.pad_index} < 4'(NUM_PADS);
    assign pad    = item.pad_index[PAD_W-1:0];

    // Look up the pad's history; insertion starts from a clean slate
    assign was_on   = online_reg[pad];
    assign inserted = item.device_connected && !was_on;
    assign prev_btn = inserted ? 16'd0 : prev_btn_reg[pad];
    assign prev_lt  = inserted ? 8'd0  : prev_lt_reg[pad];
    assign prev_rt  = inserted ? 8'd0  : prev_rt_reg[pad];

    assign lt_on      = item.raw_left_trigger  > trig_thr;
    assign rt_on      = item.raw_right_trigger > trig_thr;
    assign prev_lt_on = prev_lt > trig_thr;
    assign prev_rt_on = prev_rt > trig_thr;

    // Result flags for the item
    always_comb
    begin
        res = '0;
        if (!idx_ok)
        begin
            res.status = ST_BAD_INDEX;
        end
        else if (!item.driver_present)
        begin
            res.status = ST_NO_DRIVER;
        end
        else
        begin
            res.status       = ST_OK;
            res.is_connected = item.device_connected;
            res.was_inserted = inserted;
            res.was_removed  = was_on && !item.device_connected;
            res.data_en      = item.device_connected;
            if (item.device_connected)
            begin
                res.pressed    = item.raw_buttons & ~prev_btn;
                res.left_edge  = lt_on && !prev_lt_on;
                res.right_edge = rt_on && !prev_rt_on;
            end
        end
    end

    // History update when the item moves to the result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            online_reg <= '0;
            for (int i = 0; i < NUM_PADS; i++)
            begin
                prev_btn_reg[i] <= '0;
                prev_lt_reg[i]  <= '0;
                prev_rt_reg[i]  <= '0;
            end
        end
        else if (commit && idx_ok)
        begin
            if (!item.driver_present)
            begin
                online_reg[pad]   <= 1'b0;
                prev_btn_reg[pad] <= '0;
                prev_lt_reg[pad]  <= '0;
                prev_rt_reg[pad]  <= '0;
            end
            else
            begin
                online_reg[pad] <= item.device_connected;
                if (item.device_connected)
                begin
                    prev_btn_reg[pad] <= item.raw_buttons;
                    prev_lt_reg[pad]  <= item.raw_left_trigger;
                    prev_rt_reg[pad]  <= item.raw_right_trigger;
                end
            end
        end
    end
endmodule

// ===== hw/rtl/gamepad_input_conditioner.sv =====
// Top level of the gamepad input conditioner
//
// Usage:
//   sample : raw gamepad items in (valid/ready); one result item per sample.
//   result : conditioned items out (valid/ready), in sample order.
//   cfg    : register writes (always ready); 0 dead zone mode, 1 left dead
//            zone, 2 right dead zone, 3 trigger threshold. Write only while
//            no sample is in flight.
// Timing:
//   Two register stages: the input register holds the accepted sample, the
//   dead zone and per-pad edge logic settle combinationally, and the result
//   register presents it. One item per cycle is sustained while result.ready
//   stays high. Per-pad history sits in flip-flops written as each item
//   enters the result register, so the next sample of the same pad sees it.
// Reset: clears both stages, all per-pad history, and restores register
//   defaults (mode off, dead zones 7849 and 8689, threshold 30).
// Stall: while result.ready is low the result holds; the input register
//   still takes one more sample, after which sample.ready drops.
module gamepad_input_conditioner (
    input  logic        clk,
    input  logic        rst_n,
    gic_sample_if.sink  sample,
    gic_result_if.source result,
    gic_cfg_if.sink     cfg
);
    import gic_pkg::*;

`include "gamepad_input_conditioner_defines.svh"

    cfg_t      cfg_q;
    in_item_t  in_reg;
    in_item_t  in_next;
    logic      in_valid_reg;
    logic      in_valid_next;
    out_item_t res_reg;
    out_item_t res_next;
    logic      res_valid_reg;
    logic      res_valid_next;
    logic      advance;
    logic      take;
    logic      commit;
    axes_t     raw_axes;
    axes_t     dz_axes;
    trk_res_t  trk;

    // Handshake: the result stage frees when empty or drained
    assign advance      = !res_valid_reg || result.ready;
    assign sample.ready = !in_valid_reg || advance;
    assign take         = sample.valid && sample.ready;
    assign commit       = in_valid_reg && advance;

    gic_cfg_regs u_cfg (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .cfg_q (cfg_q)
    );

    // Input register capture
    always_comb
    begin
        in_next                   = in_reg;
        if (take)
        begin
            in_next.pad_index         = sample.pad_index;
            in_next.driver_present    = sample.driver_present;
            in_next.device_connected  = sample.device_connected;
            in_next.raw_buttons       = sample.raw_buttons;
            in_next.raw_left_trigger  = sample.raw_left_trigger;
            in_next.raw_right_trigger = sample.raw_right_trigger;
            in_next.raw_left_x        = sample.raw_left_x;
            in_next.raw_left_y        = sample.raw_left_y;
            in_next.raw_right_x       = sample.raw_right_x;
            in_next.raw_right_y       = sample.raw_right_y;
        end
    end

    assign in_valid_next = take ? 1'b1 : (advance ? 1'b0 : in_valid_reg);

    // Dead zone on the held sample
    assign raw_axes.left_x  = in_reg.raw_left_x;
    assign raw_axes.left_y  = in_reg.raw_left_y;
    assign raw_axes.right_x = in_reg.raw_right_x;
    assign raw_axes.right_y = in_reg.raw_right_y;

    gic_dead_zone u_dz (
        .cfg_q  (cfg_q),
        .raw    (raw_axes),
        .cooked (dz_axes)
    );

    gic_pad_tracker u_trk (
        .clk      (clk),
        .rst_n    (rst_n),
        .commit   (commit),
        .item     (in_reg),
        .trig_thr (cfg_q.trig_thr),
        .res      (trk)
    );

    // Assemble the result; data fields only for a connected pad
    always_comb
    begin
        res_next = res_reg;
        if (commit)
        begin
            res_next.status             = trk.status;
            res_next.is_connected       = trk.is_connected;
            res_next.was_inserted       = trk.was_inserted;
            res_next.was_removed        = trk.was_removed;
            res_next.left_x             = trk.data_en ? dz_axes.left_x  : 16'sd0;
            res_next.left_y             = trk.data_en ? dz_axes.left_y  : 16'sd0;
            res_next.right_x            = trk.data_en ? dz_axes.right_x : 16'sd0;
            res_next.right_y            = trk.data_en ? dz_axes.right_y : 16'sd0;
            res_next.held_buttons       = trk.data_en ? in_reg.raw_buttons : 16'd0;
            res_next.pressed_buttons    = trk.pressed;
            res_next.left_trigger_edge  = trk.left_edge;
            res_next.right_trigger_edge = trk.right_edge;
        end
    end

    assign res_valid_next = advance ? in_valid_reg : res_valid_reg;

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        in_reg  <= in_next;
        res_reg <= res_next;
    end

    // Result port
    assign result.valid              = res_valid_reg;
    assign result.status             = res_reg.status;
    assign result.is_connected       = res_reg.is_connected;
    assign result.was_inserted       = res_reg.was_inserted;
    assign result.was_removed        = res_reg.was_removed;
    assign result.left_x             = res_reg.left_x;
    assign result.left_y             = res_reg.left_y;
    assign result.right_x            = res_reg.right_x;
    assign result.right_y            = res_reg.right_y;
    assign result.held_buttons       = res_reg.held_buttons;
    assign result.pressed_buttons    = res_reg.pressed_buttons;
    assign result.left_trigger_edge  = res_reg.left_trigger_edge;
    assign result.right_trigger_edge = res_reg.right_trigger_edge;

    // Checks
    `GIC_ASSERT_NOW(a_pressed_in_held,
        res_valid_reg, (res_reg.pressed_buttons & ~res_reg.held_buttons) == 16'd0,
        "pressed buttons not a subset of held buttons")
    `GIC_ASSERT_NOW(a_error_zero_data,
        res_valid_reg && res_reg.status != ST_OK,
        !res_reg.is_connected && res_reg.held_buttons == 16'd0
            && res_reg.left_x == 16'sd0 && res_reg.right_y == 16'sd0,
        "error result carries data")
    `GIC_ASSERT_NOW(a_insert_connected,
        res_valid_reg && res_reg.was_inserted,
        res_reg.is_connected && !res_reg.was_removed,
        "insertion flagged on a disconnected pad")
    `GIC_ASSERT_NEXT(a_commit_fills_result,
        commit, res_valid_reg,
        "committed item did not reach the result register")
endmodule

// ===== sim/tb_gamepad_input_conditioner.sv =====
// Self-checking testbench for the gamepad input conditioner: directed and random samples
module tb_gamepad_input_conditioner;
    timeunit 1ns;
    timeprecision 1ps;

    import gic_pkg::*;

    localparam int          CYCLE_LIMIT   = 200000;
    localparam int          ITEMS_PER_RUN = 220;
    localparam int          RANDOM_RUNS   = 8;
    localparam logic [1:0]  DZ_SPARE      = 2'd3;   // unused mode, behaves as off

    logic clk = 1'b0;
    logic rst_n;

    gic_sample_if smp ();
    gic_result_if res ();
    gic_cfg_if    cfg_ch ();

    gamepad_input_conditioner u_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (smp),
        .result (res),
        .cfg    (cfg_ch)
    );

    // Raw samples waiting to be driven, conditioned results waiting to be seen
    in_item_t  sample_queue[$];
    out_item_t conditioned_queue[$];

    // Predictor copy of the registers and of the per-pad history
    cfg_t        active_cfg;
    logic        online_flag  [NUM_PADS];
    logic [15:0] last_buttons [NUM_PADS];
    logic [7:0]  last_ltrig   [NUM_PADS];
    logic [7:0]  last_rtrig   [NUM_PADS];

    int   send_idle_pct;
    int   recv_stall_pct;
    int   fail_count;
    int   cycle_count;
    logic sample_taken;

    // 10 ns clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Magnitude of a signed axis; -32768 gives 32768
    function automatic logic [16:0] axis_mag(logic signed [15:0] v);
        return v[15] ? 17'(-$signed({v[15], v})) : {1'b0, v};
    endfunction

    // Expected result of one sample; advances the per-pad history
    function automatic out_item_t condition_sample(in_item_t s);
        out_item_t   r;
        int          p;
        logic        was_on;
        logic [15:0] prior_btn;
        logic [7:0]  prior_lt;
        logic [7:0]  prior_rt;
        logic        lx_in;
        logic        ly_in;
        logic        rx_in;
        logic        ry_in;
        r = '0;
        p = int'(s.pad_index);
        if (p >= NUM_PADS)
        begin
            r.status = ST_BAD_INDEX;
            return r;
        end
        // No driver: wipe the pad, report nothing else
        if (!s.driver_present)
        begin
            online_flag[p]  = 1'b0;
            last_buttons[p] = '0;
            last_ltrig[p]   = '0;
            last_rtrig[p]   = '0;
            r.status = ST_NO_DRIVER;
            return r;
        end
        was_on = online_flag[p];
        online_flag[p]  = s.device_connected;
        r.status        = ST_OK;
        r.is_connected  = s.device_connected;
        r.was_inserted  = s.device_connected && !was_on;
        r.was_removed   = was_on && !s.device_connected;
        if (!s.device_connected)
            return r;

        // A fresh insertion starts from empty history
        prior_btn = r.was_inserted ? 16'h0 : last_buttons[p];
        prior_lt  = r.was_inserted ? 8'h0  : last_ltrig[p];
        prior_rt  = r.was_inserted ? 8'h0  : last_rtrig[p];

        lx_in = axis_mag(s.raw_left_x)  < {1'b0, active_cfg.left_dz};
        ly_in = axis_mag(s.raw_left_y)  < {1'b0, active_cfg.left_dz};
        rx_in = axis_mag(s.raw_right_x) < {1'b0, active_cfg.right_dz};
        ry_in = axis_mag(s.raw_right_y) < {1'b0, active_cfg.right_dz};
        r.left_x  = s.raw_left_x;
        r.left_y  = s.raw_left_y;
        r.right_x = s.raw_right_x;
        r.right_y = s.raw_right_y;
        if (active_cfg.dz_mode == DZ_AXIS)
        begin
            if (lx_in) r.left_x  = '0;
            if (ly_in) r.left_y  = '0;
            if (rx_in) r.right_x = '0;
            if (ry_in) r.right_y = '0;
        end
        else if (active_cfg.dz_mode == DZ_CENTER)
        begin
            if (lx_in && ly_in)
            begin
                r.left_x = '0;
                r.left_y = '0;
            end
            if (rx_in && ry_in)
            begin
                r.right_x = '0;
                r.right_y = '0;
            end
        end

        r.held_buttons       = s.raw_buttons;
        r.pressed_buttons    = s.raw_buttons & ~prior_btn;
        r.left_trigger_edge  = (s.raw_left_trigger > active_cfg.trig_thr) &&
                               !(prior_lt > active_cfg.trig_thr);
        r.right_trigger_edge = (s.raw_right_trigger > active_cfg.trig_thr) &&
                               !(prior_rt > active_cfg.trig_thr);
        last_buttons[p] = s.raw_buttons;
        last_ltrig[p]   = s.raw_left_trigger;
        last_rtrig[p]   = s.raw_right_trigger;
        return r;
    endfunction

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (want !== got)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            fail_count++;
        end
    endtask

    // Result check, register shadowing and prediction, all on the rising edge
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        in_item_t  s;
        sample_taken = 1'b0;
        if (rst_n)
        begin
            if (res.valid && res.ready)
            begin
                got.status             = res.status;
                got.is_connected       = res.is_connected;
                got.was_inserted       = res.was_inserted;
                got.was_removed        = res.was_removed;
                got.left_x             = res.left_x;
                got.left_y             = res.left_y;
                got.right_x            = res.right_x;
                got.right_y            = res.right_y;
                got.held_buttons       = res.held_buttons;
                got.pressed_buttons    = res.pressed_buttons;
                got.left_trigger_edge  = res.left_trigger_edge;
                got.right_trigger_edge = res.right_trigger_edge;
                if (conditioned_queue.size() == 0)
                begin
                    $error("result item with no sample outstanding");
                    fail_count++;
                end
                else
                begin
                    want = conditioned_queue.pop_front();
                    check_field("status", want.status, got.status);
                    check_field("is_connected", want.is_connected, got.is_connected);
                    check_field("was_inserted", want.was_inserted, got.was_inserted);
                    check_field("was_removed", want.was_removed, got.was_removed);
                    check_field("left_x", want.left_x, got.left_x);
                    check_field("left_y", want.left_y, got.left_y);
                    check_field("right_x", want.right_x, got.right_x);
                    check_field("right_y", want.right_y, got.right_y);
                    check_field("held_buttons", want.held_buttons, got.held_buttons);
                    check_field("pressed_buttons", want.pressed_buttons,
                                got.pressed_buttons);
                    check_field("left_trigger_edge", want.left_trigger_edge,
                                got.left_trigger_edge);
                    check_field("right_trigger_edge", want.right_trigger_edge,
                                got.right_trigger_edge);
                end
            end

            if (cfg_ch.valid && cfg_ch.ready)
            begin
                case (cfg_ch.reg_index)
                    REG_DZ_MODE:  active_cfg.dz_mode  = cfg_ch.reg_data[1:0];
                    REG_LEFT_DZ:  active_cfg.left_dz  = cfg_ch.reg_data;
                    REG_RIGHT_DZ: active_cfg.right_dz = cfg_ch.reg_data;
                    REG_TRIG_THR: active_cfg.trig_thr = cfg_ch.reg_data[7:0];
                    default: ;
                endcase
            end

            if (smp.valid && smp.ready)
            begin
                sample_taken        = 1'b1;
                s.pad_index         = smp.pad_index;
                s.driver_present    = smp.driver_present;
                s.device_connected  = smp.device_connected;
                s.raw_buttons       = smp.raw_buttons;
                s.raw_left_trigger  = smp.raw_left_trigger;
                s.raw_right_trigger = smp.raw_right_trigger;
                s.raw_left_x        = smp.raw_left_x;
                s.raw_left_y        = smp.raw_left_y;
                s.raw_right_x       = smp.raw_right_x;
                s.raw_right_y       = smp.raw_right_y;
                conditioned_queue.push_back(condition_sample(s));
            end
        end
    end

    // Sample driver: holds an item until taken, may idle before the next one
    always @(negedge clk)
    begin
        in_item_t nxt;
        if (!rst_n)
            smp.valid <= 1'b0;
        else if (!smp.valid || sample_taken)
        begin
            if (sample_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = sample_queue.pop_front();
                smp.valid             <= 1'b1;
                smp.pad_index         <= nxt.pad_index;
                smp.driver_present    <= nxt.driver_present;
                smp.device_connected  <= nxt.device_connected;
                smp.raw_buttons       <= nxt.raw_buttons;
                smp.raw_left_trigger  <= nxt.raw_left_trigger;
                smp.raw_right_trigger <= nxt.raw_right_trigger;
                smp.raw_left_x        <= nxt.raw_left_x;
                smp.raw_left_y        <= nxt.raw_left_y;
                smp.raw_right_x       <= nxt.raw_right_x;
                smp.raw_right_y       <= nxt.raw_right_y;
            end
            else
                smp.valid <= 1'b0;
        end
    end

    // Result side back-pressure
    always @(negedge clk)
    begin
        res.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    task automatic queue_sample(logic [2:0] pad, logic drv, logic conn, logic [15:0] btn,
                                logic [7:0] lt, logic [7:0] rt, logic [15:0] lx,
                                logic [15:0] ly, logic [15:0] rx, logic [15:0] ry);
        in_item_t s;
        s.pad_index         = pad;
        s.driver_present    = drv;
        s.device_connected  = conn;
        s.raw_buttons       = btn;
        s.raw_left_trigger  = lt;
        s.raw_right_trigger = rt;
        s.raw_left_x        = lx;
        s.raw_left_y        = ly;
        s.raw_right_x       = rx;
        s.raw_right_y       = ry;
        sample_queue.push_back(s);
    endtask

    // One register write on the config channel
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid     <= 1'b1;
        cfg_ch.reg_index <= idx;
        cfg_ch.reg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ch.ready);
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    // Wait until every sample is driven and every result seen, then let the pipe settle
    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (sample_queue.size() != 0 || smp.valid || conditioned_queue.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    function automatic logic [15:0] pick_dz();
        case ($urandom_range(0, 5))
            0:       return 16'd0;
            1:       return 16'd32768;
            2:       return 16'hFFFF;
            default: return 16'($urandom_range(1, 20000));
        endcase
    endfunction

    function automatic logic [7:0] pick_thr();
        case ($urandom_range(0, 4))
            0:       return 8'd0;
            1:       return 8'd255;
            default: return 8'($urandom);
        endcase
    endfunction

    // Trigger value, often right at the threshold
    function automatic logic [7:0] pick_trigger(logic [7:0] thr);
        int v;
        case ($urandom_range(0, 3))
            0:       v = int'(thr) + int'($urandom_range(0, 2)) - 1;
            1:       v = $urandom_range(0, 1) ? 255 : 0;
            default: v = $urandom_range(0, 255);
        endcase
        if (v < 0)   v = 0;
        if (v > 255) v = 255;
        return 8'(v);
    endfunction

    // Axis value, often near the dead zone edge or at full scale
    function automatic logic [15:0] pick_axis(logic [15:0] dz);
        int v;
        case ($urandom_range(0, 5))
            0, 1:    return 16'($urandom);
            2:       v = int'(dz) + int'($urandom_range(0, 2)) - 1;
            3:       v = $urandom_range(0, int'(dz));
            4:       v = $urandom_range(0, 1) ? 32768 : 32767;
            default: v = $urandom_range(0, 2000);
        endcase
        if (v < 0)     v = 0;
        if (v > 32768) v = 32768;
        if ($urandom_range(0, 1)) v = -v;
        return 16'(v);
    endfunction

    // Stimulus sequencing
    initial
    begin
        logic [1:0]  mode_plan [RANDOM_RUNS];
        logic [1:0]  run_mode;
        logic [15:0] run_ldz;
        logic [15:0] run_rdz;
        logic [7:0]  run_thr;
        in_item_t    s;

        mode_plan = '{DZ_AXIS, DZ_CENTER, DZ_OFF, DZ_CENTER, DZ_AXIS, DZ_SPARE,
                      DZ_CENTER, DZ_AXIS};

        rst_n                 = 1'b0;
        fail_count            = 0;
        cycle_count           = 0;
        sample_taken          = 1'b0;
        send_idle_pct         = 0;
        recv_stall_pct        = 0;
        smp.valid             = 1'b0;
        smp.pad_index         = '0;
        smp.driver_present    = 1'b0;
        smp.device_connected  = 1'b0;
        smp.raw_buttons       = '0;
        smp.raw_left_trigger  = '0;
        smp.raw_right_trigger = '0;
        smp.raw_left_x        = '0;
        smp.raw_left_y        = '0;
        smp.raw_right_x       = '0;
        smp.raw_right_y       = '0;
        res.ready             = 1'b0;
        cfg_ch.valid          = 1'b0;
        cfg_ch.reg_index      = '0;
        cfg_ch.reg_data       = '0;

        active_cfg.dz_mode  = DZ_MODE_RST;
        active_cfg.left_dz  = LEFT_DZ_RST;
        active_cfg.right_dz = RIGHT_DZ_RST;
        active_cfg.trig_thr = TRIG_THR_RST;
        for (int p = 0; p < NUM_PADS; p++)
        begin
            online_flag[p]  = 1'b0;
            last_buttons[p] = '0;
            last_ltrig[p]   = '0;
            last_rtrig[p]   = '0;
        end

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: reset registers; bad index, insertion, removal, no driver
        queue_sample(3'd5, 1, 1, 16'hFFFF, 8'd255, 8'd255, 16'h7FFF, 16'h8000, 16'h1, 16'hFFFF);
        queue_sample(3'd7, 1, 1, 16'h1234, 8'd40, 8'd40, 16'h0, 16'h0, 16'h0, 16'h0);
        queue_sample(3'd0, 1, 1, 16'hFFFF, 8'd255, 8'd31, 16'h8000, 16'h7FFF, 16'h0, 16'hFFFF);
        queue_sample(3'd0, 1, 1, 16'h00FF, 8'd30, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0);
        queue_sample(3'd0, 1, 1, 16'hFF0F, 8'd31, 8'd255, 16'h1, 16'h1, 16'h1, 16'h1);
        queue_sample(3'd0, 1, 0, 16'hFFFF, 8'd255, 8'd255, 16'h7FFF, 16'h7FFF, 16'h1, 16'h1);
        queue_sample(3'd0, 1, 0, 16'hFFFF, 8'd255, 8'd255, 16'h0, 16'h0, 16'h0, 16'h0);
        queue_sample(3'd0, 1, 1, 16'hFFFF, 8'd255, 8'd255, 16'h0, 16'h0, 16'h0, 16'h0);
        queue_sample(3'd1, 0, 1, 16'hFFFF, 8'd255, 8'd255, 16'h7FFF, 16'h0, 16'h0, 16'h0);
        queue_sample(3'd3, 1, 1, 16'hA5A5, 8'd100, 8'd100, 16'h0, 16'h0, 16'h0, 16'h0);
        queue_sample(3'd3, 0, 0, 16'h5A5A, 8'd0, 8'd0, 16'h0, 16'h0, 16'h0, 16'h0);
        queue_sample(3'd3, 1, 1, 16'hA5A5, 8'd100, 8'd100, 16'h0, 16'h0, 16'h0, 16'h0);
        wait_drained();

        // Per axis, left dead zone at full scale, right dead zone off
        write_reg(REG_DZ_MODE, {14'h3FFF, DZ_AXIS});
        write_reg(REG_LEFT_DZ, 16'd32768);
        write_reg(REG_RIGHT_DZ, 16'd0);
        queue_sample(3'd2, 1, 1, 16'h0001, 8'd0, 8'd0, 16'h8000, 16'h7FFF, 16'h8000, 16'h0);
        queue_sample(3'd2, 1, 1, 16'h8000, 8'd0, 8'd0, 16'h1, 16'hFFFF, 16'h5, 16'hFFFB);
        wait_drained();

        // Center region; right dead zone above full scale swallows everything
        write_reg(REG_DZ_MODE, {14'h0, DZ_CENTER});
        write_reg(REG_LEFT_DZ, 16'd100);
        write_reg(REG_RIGHT_DZ, 16'hFFFF);
        write_reg(REG_TRIG_THR, 16'hFF00);
        queue_sample(3'd2, 1, 1, 16'h0, 8'd1, 8'd0, 16'd50, 16'd150, 16'h7FFF, 16'h8000);
        queue_sample(3'd2, 1, 1, 16'h0, 8'd0, 8'd1, 16'hFF9D, 16'd99, 16'h0, 16'h0);
        wait_drained();

        // Spare mode acts as off; highest threshold can never be passed
        write_reg(REG_DZ_MODE, {14'h0, DZ_SPARE});
        write_reg(REG_TRIG_THR, 16'h00FF);
        queue_sample(3'd1, 1, 1, 16'hFFFF, 8'd255, 8'd255, 16'd3, 16'hFFFD, 16'd1, 16'h0);
        queue_sample(3'd1, 1, 1, 16'h0, 8'd254, 8'd0, 16'd0, 16'd0, 16'd0, 16'd0);
        wait_drained();

        // Random runs, each with its own register set and idling pattern
        for (int run = 0; run < RANDOM_RUNS; run++)
        begin
            case (run % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 46; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 46; end
                default: begin send_idle_pct = 20; recv_stall_pct = 20; end
            endcase
            run_mode = mode_plan[run];
            run_ldz  = (run == 0) ? 16'd0     : (run == 1) ? 16'd32768 : pick_dz();
            run_rdz  = (run == 0) ? 16'd32768 : (run == 1) ? 16'hFFFF  : pick_dz();
            run_thr  = (run == 2) ? 8'd0 : (run == 3) ? 8'd255 : pick_thr();
            write_reg(REG_DZ_MODE, {14'($urandom), run_mode});
            write_reg(REG_LEFT_DZ, run_ldz);
            write_reg(REG_RIGHT_DZ, run_rdz);
            write_reg(REG_TRIG_THR, {8'($urandom), run_thr});

            // Mostly good pads with a live driver; some noise and unplug cycles
            for (int i = 0; i < ITEMS_PER_RUN; i++)
            begin
                s.pad_index = ($urandom_range(0, 99) < 8) ? 3'($urandom_range(4, 7))
                                                          : 3'($urandom_range(0, 3));
                s.driver_present    = ($urandom_range(0, 99) >= 5);
                s.device_connected  = ($urandom_range(0, 99) >= 15);
                s.raw_buttons       = $urandom_range(0, 1) ? 16'($urandom)
                                                           : 16'($urandom) & 16'($urandom);
                s.raw_left_trigger  = pick_trigger(run_thr);
                s.raw_right_trigger = pick_trigger(run_thr);
                s.raw_left_x        = pick_axis(run_ldz);
                s.raw_left_y        = pick_axis(run_ldz);
                s.raw_right_x       = pick_axis(run_rdz);
                s.raw_right_y       = pick_axis(run_rdz);
                sample_queue.push_back(s);
            end
            wait_drained();
        end

        repeat (5) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ===== gamepad_input_conditioner.f =====
+incdir+hw/rtl
hw/rtl/gic_pkg.sv
hw/rtl/gic_channels.sv
hw/rtl/gic_cfg_regs.sv
hw/rtl/gic_dead_zone.sv
hw/rtl/gic_pad_tracker.sv
hw/rtl/gamepad_input_conditioner.sv
sim/tb_gamepad_input_conditioner.sv
